### rtl/core/vao_pkg.sv
// Shared types, widths and constants for the voice allocator.
package vao_pkg;

    // Fixed field widths
    localparam int OPCODE_W = 1;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int VIDX_W   = 2;
    localparam int VNOTE_W  = 8;
    localparam int VC_W     = 3;
    localparam int MOD_X_W  = 5;
    localparam int MOD_R_W  = 3;
    localparam int MOD_N    = 256;

    localparam logic [VNOTE_W-1:0] FREE_NOTE = 8'hFF;

    // Event codes
    localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_EMIT
    } t_vao_state;

    // Compare flags of one voice entry
    typedef struct packed {
        logic match;
        logic rank_is_act;
        logic rank_is_zero;
    } t_vao_cmp;

    // Remainder table: entry {x, v} holds x mod v for v in 1..7
    typedef logic [MOD_N-1:0][MOD_R_W-1:0] t_mod_tbl;

    function automatic t_mod_tbl build_mod_tbl();
        t_mod_tbl tbl;
        int       r;
        tbl = '0;
        for (int x = 0; x < (1 << MOD_X_W); x++) begin
            for (int v = 0; v < (1 << VC_W); v++) begin
                r = x;
                if (v != 0) begin
                    for (int k = 0; k < (1 << MOD_X_W); k++) begin
                        if (r >= v) begin
                            r = r - v;
                        end
                    end
                end
                tbl[x * (1 << VC_W) + v] = MOD_R_W'(r);
            end
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod_tbl();

endpackage

### rtl/core/voice_allocator_oldest_steal.sv
// Top level of the voice allocator: config register, voice store, sequencer, output register.
// Polyphonic voice allocator with oldest-note stealing. Each event word (note on or off)
// is handled by a sequencer that walks the voices in use one per cycle through a single
// compare/update unit. An event is accepted, the voices in use are scanned and a decision
// is made; a steal or a release then walks the voices again to rewrite their ranks. A
// result is then loaded into the output register; an ignored event yields no result.
// With no voices in use an event is dropped in its accept cycle. A result waits in the
// load state for as long as the previous word stays untaken in the output register.
// The input is not ready while an event is in progress; the next event may be accepted
// while a finished result still waits in the output register. The voice_count register
// may be written only while the block is idle; values above MAX_VOICES act as MAX_VOICES
// and zero makes every event ignored.
module voice_allocator_oldest_steal
    import vao_pkg::*;
#(
    parameter int MAX_VOICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [VC_W-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [NOTE_W-1:0]   i_note,
    input  logic [VEL_W-1:0]    i_velocity,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VIDX_W-1:0]   o_voice_index,
    output logic                o_gate_on,
    output logic [VNOTE_W-1:0]  o_voice_note,
    output logic [VNOTE_W-1:0]  o_voice_velocity
);

    localparam int IDX_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int ACT_W  = $clog2(MAX_VOICES + 1);
    localparam int CW     = (IDX_W > VC_W) ? IDX_W : VC_W;
    localparam int AW     = (ACT_W > VC_W) ? ACT_W : VC_W;
    localparam logic [VC_W-1:0] VC_SAT =
        (MAX_VOICES > 7) ? 3'd7 : VC_W'(MAX_VOICES);

    // Control state
    t_vao_state         r_state, n_state;
    logic [VC_W-1:0]    r_cfg, n_cfg;
    logic [VC_W-1:0]    r_vc, n_vc;
    logic [IDX_W-1:0]   r_walk, n_walk;
    logic [ACT_W-1:0]   r_active, n_active;
    logic               r_match_ok, n_match_ok;
    logic               r_free_ok, n_free_ok;
    logic               r_steal_ok, n_steal_ok;
    logic               r_rotate, n_rotate;
    logic               r_gate, n_gate;
    logic               r_out_valid, n_out_valid;
    logic [VNOTE_W-1:0] r_notes [MAX_VOICES];
    logic [VNOTE_W-1:0] n_notes [MAX_VOICES];
    logic [RANK_W-1:0]  r_rank [MAX_VOICES];
    logic [RANK_W-1:0]  n_rank [MAX_VOICES];

    // Event and search payload
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [NOTE_W-1:0]   r_note, n_note;
    logic [VEL_W-1:0]    r_vel, n_vel;
    logic [IDX_W-1:0]    r_match_idx, n_match_idx;
    logic [RANK_W-1:0]   r_match_rank, n_match_rank;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [IDX_W-1:0]    r_steal_idx, n_steal_idx;
    logic [IDX_W-1:0]    r_hit_idx, n_hit_idx;
    logic [RANK_W-1:0]   r_gap, n_gap;
    logic [VIDX_W-1:0]   r_o_idx, n_o_idx;
    logic                r_o_gate, n_o_gate;
    logic [VNOTE_W-1:0]  r_o_note, n_o_note;
    logic [VNOTE_W-1:0]  r_o_vel, n_o_vel;

    logic [VC_W-1:0]    vc_now;
    logic               walk_last;
    logic               act_full;
    t_vao_cmp           cmp;
    logic [RANK_W-1:0]  next_rank;

    assign vc_now    = (r_cfg > VC_SAT) ? VC_SAT : r_cfg;
    assign walk_last = (CW'(r_walk) == CW'(r_vc) - CW'(1));
    assign act_full  = (AW'(r_active) == AW'(r_vc));

    // Shared per-voice unit
    vao_voice_unit #(
        .RANK_W (RANK_W),
        .ACT_W  (ACT_W)
    ) u_unit (
        .i_note_q    (r_notes[r_walk]),
        .i_rank_q    (r_rank[r_walk]),
        .i_evt_note  (r_note),
        .i_active    (r_active),
        .i_vc        (r_vc),
        .i_gap       (r_gap),
        .i_is_hit    (r_walk == r_hit_idx),
        .i_rotate    (r_rotate),
        .o_cmp       (cmp),
        .o_next_rank (next_rank)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_voice_index    = r_o_idx;
    assign o_gate_on        = r_o_gate;
    assign o_voice_note     = r_o_note;
    assign o_voice_velocity = r_o_vel;

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cfg        = r_cfg;
        n_vc         = r_vc;
        n_walk       = r_walk;
        n_active     = r_active;
        n_match_ok   = r_match_ok;
        n_free_ok    = r_free_ok;
        n_steal_ok   = r_steal_ok;
        n_rotate     = r_rotate;
        n_gate       = r_gate;
        n_out_valid  = r_out_valid;
        n_notes      = r_notes;
        n_rank       = r_rank;
        n_op         = r_op;
        n_note       = r_note;
        n_vel        = r_vel;
        n_match_idx  = r_match_idx;
        n_match_rank = r_match_rank;
        n_free_idx   = r_free_idx;
        n_steal_idx  = r_steal_idx;
        n_hit_idx    = r_hit_idx;
        n_gap        = r_gap;
        n_o_idx      = r_o_idx;
        n_o_gate     = r_o_gate;
        n_o_note     = r_o_note;
        n_o_vel      = r_o_vel;

        // Take config words
        if (i_cfg_valid) begin
            n_cfg = i_cfg_data;
        end

        // Drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_opcode;
                    n_note     = i_note;
                    n_vel      = i_velocity;
                    n_vc       = vc_now;
                    n_walk     = '0;
                    n_match_ok = 1'b0;
                    n_free_ok  = 1'b0;
                    n_steal_ok = 1'b0;
                    if (vc_now != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Record first match, first free rank slot and oldest voice
                if (!r_match_ok && cmp.match) begin
                    n_match_ok   = 1'b1;
                    n_match_idx  = r_walk;
                    n_match_rank = r_rank[r_walk];
                end
                if (!r_free_ok && cmp.rank_is_act) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_walk;
                end
                if (!r_steal_ok && cmp.rank_is_zero) begin
                    n_steal_ok  = 1'b1;
                    n_steal_idx = r_walk;
                end
                if (walk_last) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_walk = r_walk + IDX_W'(1);
                end
            end
            ST_DECIDE: begin
                n_walk  = '0;
                n_state = ST_IDLE;
                if (r_op == OP_NOTE_ON) begin
                    n_gate = 1'b1;
                    if (r_match_ok) begin
                        n_state = ST_IDLE;
                    end else if (!act_full) begin
                        if (r_free_ok) begin
                            n_notes[r_free_idx] = {1'b0, r_note};
                            n_active            = r_active + ACT_W'(1);
                            n_hit_idx           = r_free_idx;
                            n_state             = ST_EMIT;
                        end
                    end else if (r_steal_ok) begin
                        n_notes[r_steal_idx] = {1'b0, r_note};
                        n_hit_idx            = r_steal_idx;
                        n_rotate             = 1'b1;
                        n_state              = ST_UPDATE;
                    end
                end else begin
                    n_gate = 1'b0;
                    if (r_match_ok) begin
                        n_notes[r_match_idx] = FREE_NOTE;
                        n_hit_idx            = r_match_idx;
                        n_gap                = r_match_rank;
                        n_rotate             = 1'b0;
                        if (r_active != '0) begin
                            n_active = r_active - ACT_W'(1);
                        end
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                // Rewrite one rank per cycle
                n_rank[r_walk] = next_rank;
                if (walk_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_walk = r_walk + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                // Load the output word when the register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_idx     = VIDX_W'(r_hit_idx);
                    n_o_gate    = r_gate;
                    n_o_note    = r_gate ? {1'b0, r_note} : FREE_NOTE;
                    n_o_vel     = r_gate ? {1'b0, r_vel} : FREE_NOTE;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and voice state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= VC_W'(4);
            r_vc        <= '0;
            r_walk      <= '0;
            r_active    <= '0;
            r_match_ok  <= 1'b0;
            r_free_ok   <= 1'b0;
            r_steal_ok  <= 1'b0;
            r_rotate    <= 1'b0;
            r_gate      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_VOICES; i++) begin
                r_notes[i] <= FREE_NOTE;
                r_rank[i]  <= RANK_W'(i);
            end
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_vc        <= n_vc;
            r_walk      <= n_walk;
            r_active    <= n_active;
            r_match_ok  <= n_match_ok;
            r_free_ok   <= n_free_ok;
            r_steal_ok  <= n_steal_ok;
            r_rotate    <= n_rotate;
            r_gate      <= n_gate;
            r_out_valid <= n_out_valid;
            r_notes     <= n_notes;
            r_rank      <= n_rank;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_note       <= n_note;
        r_vel        <= n_vel;
        r_match_idx  <= n_match_idx;
        r_match_rank <= n_match_rank;
        r_free_idx   <= n_free_idx;
        r_steal_idx  <= n_steal_idx;
        r_hit_idx    <= n_hit_idx;
        r_gap        <= n_gap;
        r_o_idx      <= n_o_idx;
        r_o_gate     <= n_o_gate;
        r_o_note     <= n_o_note;
        r_o_vel      <= n_o_vel;
    end

`ifndef SYNTH
    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_active) <= AW'(MAX_VOICES)))
        else $error("active count exceeds voice pool");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN || r_state == ST_UPDATE) |->
            (CW'(r_walk) < CW'(r_vc))))
        else $error("voice walk beyond voices in use");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT && (!r_out_valid || i_out_ready)) |=>
            (r_out_valid && r_state == ST_IDLE)))
        else $error("result not loaded into output register");

    a_release_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_out_valid && !o_gate_on) |->
            (o_voice_note == FREE_NOTE && o_voice_velocity == FREE_NOTE)))
        else $error("release word without free marker");
`endif

endmodule

### rtl/core/vao_voice_unit.sv
// Shared compare and rank-update unit applied to one voice entry per cycle.
module vao_voice_unit
    import vao_pkg::*;
#(
    parameter int RANK_W = 2,
    parameter int ACT_W  = 3
) (
    input  logic [VNOTE_W-1:0] i_note_q,
    input  logic [RANK_W-1:0]  i_rank_q,
    input  logic [NOTE_W-1:0]  i_evt_note,
    input  logic [ACT_W-1:0]   i_active,
    input  logic [VC_W-1:0]    i_vc,
    input  logic [RANK_W-1:0]  i_gap,
    input  logic               i_is_hit,
    input  logic               i_rotate,
    output t_vao_cmp           o_cmp,
    output logic [RANK_W-1:0]  o_next_rank
);

    logic [MOD_X_W-1:0] rot_x;
    logic [MOD_R_W-1:0] rot_r;

    // Compare the entry against the event and the active count
    always_comb begin
        o_cmp.match        = (i_note_q == {1'b0, i_evt_note});
        o_cmp.rank_is_act  = (ACT_W'(i_rank_q) == i_active);
        o_cmp.rank_is_zero = (i_rank_q == '0);
    end

    // Rotate down with wrap: (rank + vc - 1) mod vc
    assign rot_x = MOD_X_W'(i_rank_q) + MOD_X_W'(i_vc) - MOD_X_W'(1);
    assign rot_r = MOD_TBL[{rot_x, i_vc}];

    // Pick the new rank: rotation, or gap close around the released voice
    always_comb begin
        if (i_rotate) begin
            o_next_rank = RANK_W'(rot_r);
        end else if (i_is_hit) begin
            o_next_rank = RANK_W'(i_vc - VC_W'(1));
        end else if (i_rank_q > i_gap) begin
            o_next_rank = i_rank_q - RANK_W'(1);
        end else begin
            o_next_rank = i_rank_q;
        end
    end

endmodule

### tb/voice_alloc_checker.sv
// Checker for the voice allocator: tracks voice state, predicts each event and compares results.
module voice_alloc_checker
    import vao_pkg::*;
#(
    parameter int MAX_VOICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [VC_W-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [NOTE_W-1:0]   i_note,
    input  logic [VEL_W-1:0]    i_velocity,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [VIDX_W-1:0]   i_voice_index,
    input  logic                i_gate_on,
    input  logic [VNOTE_W-1:0]  i_voice_note,
    input  logic [VNOTE_W-1:0]  i_voice_velocity,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [VC_W-1:0] VOICE_COUNT_RESET = VC_W'(4);

    typedef struct packed {
        logic [VIDX_W-1:0]  voice_index;
        logic               gate_on;
        logic [VNOTE_W-1:0] voice_note;
        logic [VNOTE_W-1:0] voice_velocity;
    } t_voice_event;

    // Shadow of the allocator state
    logic [VNOTE_W-1:0] held_note  [MAX_VOICES];
    logic [VIDX_W-1:0]  voice_rank [MAX_VOICES];
    logic [VC_W-1:0]    live_count;
    logic [VC_W-1:0]    voice_limit;

    t_voice_event due_voice_events[$];

    // Apply one event to the shadow state; return 1 when it yields a voice event
    function automatic bit allocate_voice(input logic [OPCODE_W-1:0] op,
                                          input logic [NOTE_W-1:0] nt,
                                          input logic [VEL_W-1:0] vel,
                                          output t_voice_event ev);
        int used;
        int slot;
        int gap;
        int i;
        int j;
        used = (int'(voice_limit) > MAX_VOICES) ? MAX_VOICES : int'(voice_limit);
        ev   = '0;
        slot = -1;
        if (used == 0) begin
            return 0;
        end
        if (op == OP_NOTE_ON) begin
            // Drop a note that already sounds on a voice in use
            for (i = 0; i < used; i++) begin
                if (held_note[i] == VNOTE_W'(nt)) begin
                    return 0;
                end
            end
            if (int'(live_count) != used) begin
                // Take the voice whose rank equals the active count
                for (i = 0; i < used; i++) begin
                    if (slot < 0 && int'(voice_rank[i]) == int'(live_count)) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    return 0;
                end
                live_count = live_count + 1'b1;
            end else begin
                // Steal the oldest voice and rotate every rank down with wrap
                for (i = 0; i < used; i++) begin
                    if (slot < 0 && voice_rank[i] == '0) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    return 0;
                end
                for (j = 0; j < used; j++) begin
                    voice_rank[j] = VIDX_W'((int'(voice_rank[j]) + used - 1) % used);
                end
            end
            held_note[slot] = VNOTE_W'(nt);
            ev.voice_index    = VIDX_W'(slot);
            ev.gate_on        = 1'b1;
            ev.voice_note     = VNOTE_W'(nt);
            ev.voice_velocity = VNOTE_W'(vel);
            return 1;
        end
        // Release the lowest voice holding the note and close the rank gap
        for (i = 0; i < used; i++) begin
            if (slot < 0 && held_note[i] == VNOTE_W'(nt)) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            return 0;
        end
        gap = int'(voice_rank[slot]);
        held_note[slot] = FREE_NOTE;
        for (j = 0; j < used; j++) begin
            if (j != slot && int'(voice_rank[j]) > gap) begin
                voice_rank[j] = voice_rank[j] - 1'b1;
            end
        end
        voice_rank[slot] = VIDX_W'(used - 1);
        if (live_count != '0) begin
            live_count = live_count - 1'b1;
        end
        ev.voice_index    = VIDX_W'(slot);
        ev.gate_on        = 1'b0;
        ev.voice_note     = FREE_NOTE;
        ev.voice_velocity = FREE_NOTE;
        return 1;
    endfunction

    // Track configuration and events, compare each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_voice_event ev;
        t_voice_event got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
                held_note[i]  = FREE_NOTE;
                voice_rank[i] = VIDX_W'(i);
            end
            live_count   = '0;
            voice_limit  = VOICE_COUNT_RESET;
            o_fail_count = 0;
            due_voice_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                voice_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (allocate_voice(i_opcode, i_note, i_velocity, ev)) begin
                    due_voice_events.push_back(ev);
                end
            end
            if (i_out_valid && i_out_ready) begin
                got.voice_index    = i_voice_index;
                got.gate_on        = i_gate_on;
                got.voice_note     = i_voice_note;
                got.voice_velocity = i_voice_velocity;
                if (due_voice_events.size() == 0) begin
                    $error("unexpected result word: voice %0d gate %0d note %0d velocity %0d",
                           got.voice_index, got.gate_on, got.voice_note, got.voice_velocity);
                    o_fail_count++;
                end else begin
                    ev = due_voice_events.pop_front();
                    if (got.voice_index !== ev.voice_index) begin
                        $error("voice_index: expected %0d, got %0d",
                               ev.voice_index, got.voice_index);
                        o_fail_count++;
                    end
                    if (got.gate_on !== ev.gate_on) begin
                        $error("gate_on: expected %0d, got %0d", ev.gate_on, got.gate_on);
                        o_fail_count++;
                    end
                    if (got.voice_note !== ev.voice_note) begin
                        $error("voice_note: expected %0d, got %0d",
                               ev.voice_note, got.voice_note);
                        o_fail_count++;
                    end
                    if (got.voice_velocity !== ev.voice_velocity) begin
                        $error("voice_velocity: expected %0d, got %0d",
                               ev.voice_velocity, got.voice_velocity);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_voice_events.size();
    end

endmodule

### tb/tb_voice_allocator_oldest_steal.sv
// Testbench top for the voice allocator: clock, reset, event and config stimulus, verdict.
module tb_voice_allocator_oldest_steal;
    import vao_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_WAIT  = 20;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_EVENTS = 140;
    localparam int NOTE_SPREAD  = 12;
    localparam int PHASES       = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [VC_W-1:0]     cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic [OPCODE_W-1:0] opcode    = OP_NOTE_ON;
    logic [NOTE_W-1:0]   note      = '0;
    logic [VEL_W-1:0]    velocity  = '0;
    logic                out_ready = 1'b0;

    logic                cfg_ready;
    logic                in_ready;
    logic                out_valid;
    logic [VIDX_W-1:0]   voice_index;
    logic                gate_on;
    logic [VNOTE_W-1:0]  voice_note;
    logic [VNOTE_W-1:0]  voice_velocity;

    int fail_count;
    int pending;
    int cycle_count = 0;

    bit steady_in  = 1'b0;
    bit steady_out = 1'b0;
    bit hold_req   = 1'b0;
    bit maybe_held [128];

    voice_allocator_oldest_steal #(
        .MAX_VOICES (4)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_note           (note),
        .i_velocity       (velocity),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_voice_index    (voice_index),
        .o_gate_on        (gate_on),
        .o_voice_note     (voice_note),
        .o_voice_velocity (voice_velocity)
    );

    voice_alloc_checker #(
        .MAX_VOICES (4)
    ) u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_note           (note),
        .i_velocity       (velocity),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_voice_index    (voice_index),
        .i_gate_on        (gate_on),
        .i_voice_note     (voice_note),
        .i_voice_velocity (voice_velocity),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** voice_allocator_oldest_steal: FAILED **");
            $finish;
        end
    end

    // Offer one event word after a random gap and hold it until accepted
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [NOTE_W-1:0] nt,
                             input logic [VEL_W-1:0] vel);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        note     <= nt;
        velocity <= vel;
        maybe_held[nt] = (op == OP_NOTE_ON);
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Drop the input and wait until every predicted result word has come
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Write the voice count once the block has gone idle
    task automatic set_voice_count(input logic [VC_W-1:0] count);
        drain_results();
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall per word, one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            stall = steady_out ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Event stimulus and verdict
    initial begin
        logic [VC_W-1:0] plan [PHASES];
        int              pool_base;
        int              pick;
        int              found;
        logic [NOTE_W-1:0] nt;
        plan = '{3'd4, 3'd3, 3'd7, 3'd1, 3'd2, 3'd0, 3'd6, 3'd5, 3'd4, 3'd2};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Fill three voices, two of them with extreme notes and velocities
        set_voice_count(3'd4);
        send_word(OP_NOTE_ON, 7'd0, 7'd127);
        send_word(OP_NOTE_ON, 7'd127, 7'd0);
        send_word(OP_NOTE_ON, 7'd60, 7'd64);
        // Note already sounding, then release of a note nobody holds
        send_word(OP_NOTE_ON, 7'd60, 7'd1);
        send_word(OP_NOTE_OFF, 7'd99, 7'd0);
        // Shrink the pool: release, then a note-on with no voice of matching rank
        set_voice_count(3'd1);
        send_word(OP_NOTE_OFF, 7'd0, 7'd0);
        send_word(OP_NOTE_ON, 7'd5, 7'd3);
        // Steal lands on a free voice, which leaves more notes than the active count
        set_voice_count(3'd2);
        send_word(OP_NOTE_ON, 7'd77, 7'd100);
        // Release everything; the last release hits the active count floor
        set_voice_count(3'd4);
        send_word(OP_NOTE_OFF, 7'd127, 7'd127);
        send_word(OP_NOTE_OFF, 7'd60, 7'd0);
        send_word(OP_NOTE_OFF, 7'd77, 7'd0);
        // Build the same note on two voices, then release both in turn
        send_word(OP_NOTE_ON, 7'd10, 7'd85);
        send_word(OP_NOTE_ON, 7'd20, 7'd42);
        send_word(OP_NOTE_ON, 7'd30, 7'd21);
        set_voice_count(3'd3);
        send_word(OP_NOTE_OFF, 7'd20, 7'd0);
        send_word(OP_NOTE_ON, 7'd10, 7'd106);
        set_voice_count(3'd4);
        send_word(OP_NOTE_OFF, 7'd10, 7'd0);
        send_word(OP_NOTE_OFF, 7'd10, 7'd0);
        // No voices in use: everything ignored
        set_voice_count(3'd0);
        send_word(OP_NOTE_ON, 7'd45, 7'd90);
        send_word(OP_NOTE_OFF, 7'd30, 7'd0);

        // Random phases, each over a fresh pool after releasing what may still sound
        for (int p = 0; p < PHASES; p++) begin
            set_voice_count(3'd4);
            steady_in = 1'b0;
            for (int k = 0; k < 128; k++) begin
                if (maybe_held[k]) begin
                    send_word(OP_NOTE_OFF, NOTE_W'(k), NOTE_W'($urandom_range(0, 127)));
                    send_word(OP_NOTE_OFF, NOTE_W'(k), NOTE_W'($urandom_range(0, 127)));
                end
            end
            set_voice_count(plan[p]);
            steady_in  = ($urandom_range(0, 3) == 0);
            steady_out = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                // Keep offering while the result side holds off
                steady_in = 1'b1;
                hold_req  = 1'b1;
            end
            pool_base = $urandom_range(0, 127);
            for (int i = 0; i < ((plan[p] == 0) ? 12 : PHASE_EVENTS); i++) begin
                if (i == PHASE_EVENTS / 2) begin
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                nt   = NOTE_W'(pool_base + $urandom_range(0, NOTE_SPREAD - 1));
                if (pick < 8) begin
                    send_word(OPCODE_W'($urandom_range(0, 1)), NOTE_W'($urandom_range(0, 127)),
                              VEL_W'($urandom_range(0, 127)));
                end else if (pick < 58) begin
                    send_word(OP_NOTE_ON, nt, VEL_W'($urandom_range(0, 127)));
                end else if (pick < 88) begin
                    // Release a note that is likely sounding
                    found = -1;
                    for (int k = 0; k < NOTE_SPREAD; k++) begin
                        if (found < 0 && maybe_held[NOTE_W'(nt + k)]) begin
                            found = k;
                        end
                    end
                    if (found >= 0) begin
                        nt = NOTE_W'(nt + found);
                    end
                    send_word(OP_NOTE_OFF, nt, VEL_W'($urandom_range(0, 127)));
                end else begin
                    send_word(OP_NOTE_OFF, nt, VEL_W'($urandom_range(0, 127)));
                end
            end
        end

        drain_results();
        repeat (SETTLE_WAIT + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** voice_allocator_oldest_steal: PASSED **");
        end else begin
            $display("** voice_allocator_oldest_steal: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/vao_pkg.sv
rtl/core/vao_voice_unit.sv
rtl/core/voice_allocator_oldest_steal.sv
tb/voice_alloc_checker.sv
tb/tb_voice_allocator_oldest_steal.sv
